// File: design/stpe_pkg.sv
`default_nettype none

package stpe_pkg;

  // widths fixed by the word formats
  localparam int SAMPLE_W            = 24;
  localparam int PEAK_BITS           = 31;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam logic [PEAK_BITS-1:0] PEAK_MAX = {PEAK_BITS{1'b1}};

  // input word: one stereo pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } stpe_in_t;

  // output word: item peak and running peak
  typedef struct packed {
    logic [PEAK_BITS-1:0] item_peak_x128;
    logic [PEAK_BITS-1:0] running_peak_x128;
  } stpe_out_t;

  // stage load enables shared by both lanes
  typedef struct packed {
    logic ld_hist;
    logic ld_coef;
    logic ld_mag;
    logic ld_peak;
  } stpe_adv_t;

endpackage

`default_nettype wire

// File: design/stpe_lane.sv
`default_nettype none

module stpe_lane #(
  parameter int SampleBits = stpe_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire stpe_pkg::stpe_adv_t            adv,
  input  wire logic [stpe_pkg::SAMPLE_W-1:0]  sample,
  output logic      [stpe_pkg::PEAK_BITS-1:0] peak
);
  import stpe_pkg::*;

  // signed working width and magnitude width of the candidates
  localparam int W  = SampleBits + 9;
  localparam int MW = SampleBits + 8;

  logic signed [SampleBits-1:0] snew;
  logic signed [SampleBits-1:0] hist [4];
  logic signed [W-1:0]          hw   [4];
  logic signed [W-1:0]          x_c, y_c, z_c, b_c;
  logic signed [W-1:0]          x, y, z, b;
  logic signed [W-1:0]          v1, v2, v3;
  logic        [MW-1:0]         mag_c [4];
  logic        [MW-1:0]         mag   [4];
  logic        [MW-1:0]         max01, max23, mx;
  logic        [PEAK_BITS-1:0]  peak_c;

  function automatic logic [MW-1:0] abs_val(input logic signed [W-1:0] v);
    logic signed [W-1:0] n;
    n = -v;
    return v[W-1] ? MW'(n) : MW'(v);
  endfunction

  // take the low sample bits as two's complement; wider settings zero-extend the sample word
  generate
    if (SampleBits <= SAMPLE_W) begin : g_narrow
      assign snew = sample[SampleBits-1:0];
    end else begin : g_wide
      assign snew = SampleBits'(sample);
    end
  endgenerate

  // four-sample history, newest in hist[3]
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) hist[i] <= '0;
    end else if (adv.ld_hist) begin
      hist[0] <= hist[1];
      hist[1] <= hist[2];
      hist[2] <= hist[3];
      hist[3] <= snew;
    end
  end

  // polynomial coefficients
  always_comb begin
    for (int i = 0; i < 4; i++) hw[i] = W'(hist[i]);
    x_c = hw[2] - hw[0];
    y_c = (hw[0] <<< 1) - (hw[1] <<< 2) - hw[1] + (hw[2] <<< 2) - hw[3];
    z_c = (hw[1] <<< 1) + hw[1] - (hw[2] <<< 1) - hw[2] + hw[3] - hw[0];
    b_c = hw[1] <<< 7;
  end

  always_ff @(posedge clk) begin
    if (adv.ld_coef) begin
      x <= x_c;
      y <= y_c;
      z <= z_c;
      b <= b_c;
    end
  end

  // interpolants at quarter, half and three-quarter points
  always_comb begin
    v1 = b + (x <<< 4) + (y <<< 2) + z;
    v2 = b + (x <<< 5) + (y <<< 4) + (z <<< 3);
    v3 = b + (x <<< 5) + (x <<< 4) + (y <<< 5) + (y <<< 2)
           + (z <<< 4) + (z <<< 3) + (z <<< 1) + z;
    mag_c[0] = abs_val(b);
    mag_c[1] = abs_val(v1);
    mag_c[2] = abs_val(v2);
    mag_c[3] = abs_val(v3);
  end

  always_ff @(posedge clk) begin
    if (adv.ld_mag) begin
      for (int i = 0; i < 4; i++) mag[i] <= mag_c[i];
    end
  end

  // largest candidate of this channel
  always_comb begin
    max01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    max23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
    mx    = (max23 > max01) ? max23 : max01;
  end

  // clamp to the output width when the samples are wide
  generate
    if (MW > PEAK_BITS) begin : g_sat
      assign peak_c = (mx > MW'(PEAK_MAX)) ? PEAK_MAX : PEAK_BITS'(mx);
    end else begin : g_nosat
      assign peak_c = PEAK_BITS'(mx);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv.ld_peak) begin
      peak <= peak_c;
    end
  end

endmodule

`default_nettype wire

// File: design/stpe_merge.sv
`default_nettype none

module stpe_merge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           ld_out,
  input  wire logic [stpe_pkg::PEAK_BITS-1:0] left_peak,
  input  wire logic [stpe_pkg::PEAK_BITS-1:0] right_peak,
  output logic      [stpe_pkg::PEAK_BITS-1:0] item_peak,
  output logic      [stpe_pkg::PEAK_BITS-1:0] running_peak
);
  import stpe_pkg::*;

  logic [PEAK_BITS-1:0] item_c;
  logic [PEAK_BITS-1:0] hold_next;

  // larger of the two channels, then the running maximum
  always_comb begin
    item_c    = (right_peak > left_peak) ? right_peak : left_peak;
    hold_next = (item_c > running_peak) ? item_c : running_peak;
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      item_peak <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
    end else if (ld_out) begin
      running_peak <= hold_next;
    end
  end

endmodule

`default_nettype wire

// File: design/stereo_true_peak_estimator.sv
// channel   direction  handshake                 word
// sample    in         sample_valid/sample_stall stpe_in_t  (left, right)
// peak      out        peak_valid/peak_stall     stpe_out_t (item, running)
//
// One word per cycle sustained while the output is not stalled; a result passes
// through history, coefficients, magnitudes, lane max and merge after its sample word is accepted.
// Each stage holds its own valid bit, so bubbles close up under a stall and
// the input keeps being taken while a finished result waits, as long as a stage is free.
// Synchronous reset clears the histories, the running peak and all valid bits.
`default_nettype none

module stereo_true_peak_estimator #(
  parameter int SampleBits = stpe_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire stpe_pkg::stpe_in_t  sample_word,
  output logic                     peak_valid,
  input  wire logic                peak_stall,
  output stpe_pkg::stpe_out_t      peak_word
);
  import stpe_pkg::*;

  // valid bits of history, coefficient, magnitude, lane peak and output stages
  logic [4:0] vld;
  logic [4:0] vld_next;
  logic [4:0] moving;
  logic [4:0] free;
  logic       ld_out;
  stpe_adv_t  adv;

  logic [PEAK_BITS-1:0] left_peak, right_peak;
  logic [PEAK_BITS-1:0] item_peak, running_peak;

  // stage advance chain, from the output backward
  always_comb begin
    moving[4] = vld[4] && !peak_stall;
    free[4]   = !vld[4] || moving[4];
    for (int i = 3; i >= 0; i--) begin
      moving[i] = vld[i] && free[i+1];
      free[i]   = !vld[i] || moving[i];
    end
    adv.ld_hist = sample_valid && free[0];
    adv.ld_coef = vld[0] && free[1];
    adv.ld_mag  = vld[1] && free[2];
    adv.ld_peak = vld[2] && free[3];
    ld_out      = vld[3] && free[4];
    vld_next[0] = adv.ld_hist || (vld[0] && !moving[0]);
    vld_next[1] = adv.ld_coef || (vld[1] && !moving[1]);
    vld_next[2] = adv.ld_mag  || (vld[2] && !moving[2]);
    vld_next[3] = adv.ld_peak || (vld[3] && !moving[3]);
    vld_next[4] = ld_out      || (vld[4] && !moving[4]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // one lane per channel
  stpe_lane #(
    .SampleBits(SampleBits)
  ) u_left (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .sample(sample_word.left_sample),
    .peak  (left_peak)
  );

  stpe_lane #(
    .SampleBits(SampleBits)
  ) u_right (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .sample(sample_word.right_sample),
    .peak  (right_peak)
  );

  // combine lanes and keep the running peak
  stpe_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ld_out      (ld_out),
    .left_peak   (left_peak),
    .right_peak  (right_peak),
    .item_peak   (item_peak),
    .running_peak(running_peak)
  );

  // ports
  always_comb begin
    sample_stall                = !free[0];
    peak_valid                  = vld[4];
    peak_word.item_peak_x128    = item_peak;
    peak_word.running_peak_x128 = running_peak;
  end

endmodule

`default_nettype wire

// File: bench/stereo_true_peak_estimator_tb.sv
`timescale 1ns / 100ps

module stereo_true_peak_estimator_tb;
  import stpe_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  // one row of the directed table; want is only used when fixed is set
  typedef struct packed {
    logic      fixed;
    stpe_in_t  word;
    stpe_out_t want;
  } dir_row_t;

  localparam smp_t FS_POS      = 24'sh7FFFFF;
  localparam smp_t FS_NEG      = 24'sh800000;
  localparam int   N_DIR       = 21;
  localparam int   N_RANDOM    = 1250;
  localparam int   MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  stpe_in_t  sample_word = '0;
  logic      peak_valid;
  logic      peak_stall = 1'b0;
  stpe_out_t peak_word;

  // predictor state: per-channel history (index 3 newest) and running peak
  smp_t                 left_hist  [0:3];
  smp_t                 right_hist [0:3];
  logic [PEAK_BITS-1:0] peak_hold_m;

  stpe_out_t peak_due [$];
  stpe_out_t peak_want;
  int        words_sent = 0;
  int        mismatches = 0;
  logic      calm;

  // full-scale negative from zero history: worst candidate is 9 * 2^23 * 128 / 128
  dir_row_t dir_table [0:N_DIR-1] = '{
    {1'b1, 24'sd0,       24'sd0,       31'd0,        31'd0},
    {1'b1, FS_NEG,       FS_NEG,       31'd75497472, 31'd75497472},
    {1'b0, FS_POS,       FS_POS,       31'd0,        31'd0},
    {1'b0, FS_NEG,       FS_POS,       31'd0,        31'd0},
    {1'b0, FS_POS,       FS_NEG,       31'd0,        31'd0},
    {1'b0, FS_NEG,       FS_NEG,       31'd0,        31'd0},
    {1'b0, 24'sd0,       24'sd0,       31'd0,        31'd0},
    {1'b0, 24'sd1,       -24'sd1,      31'd0,        31'd0},
    {1'b0, -24'sd1,      24'sd1,       31'd0,        31'd0},
    {1'b0, FS_POS,       24'sd0,       31'd0,        31'd0},
    {1'b0, FS_NEG,       24'sd0,       31'd0,        31'd0},
    {1'b0, FS_POS,       24'sd0,       31'd0,        31'd0},
    {1'b0, 24'sd0,       FS_NEG,       31'd0,        31'd0},
    {1'b0, 24'sd0,       FS_POS,       31'd0,        31'd0},
    {1'b0, 24'sd0,       FS_NEG,       31'd0,        31'd0},
    {1'b0, 24'sh555555,  24'shAAAAAA,  31'd0,        31'd0},
    {1'b0, 24'shAAAAAA,  24'sh555555,  31'd0,        31'd0},
    {1'b0, 24'sd0,       24'sd0,       31'd0,        31'd0},
    {1'b0, 24'sd0,       24'sd0,       31'd0,        31'd0},
    {1'b0, 24'sd0,       24'sd0,       31'd0,        31'd0},
    {1'b0, 24'sd0,       24'sd0,       31'd0,        31'd0}
  };

  stereo_true_peak_estimator DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .peak_valid   (peak_valid),
    .peak_stall   (peak_stall),
    .peak_word    (peak_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // no idling on either side for a stretch in the middle of the run
  assign calm = (words_sent >= 500) && (words_sent < 800);

  // largest magnitude times 128 over h1 and the quarter, half, three-quarter interpolants
  function automatic logic [PEAK_BITS-1:0] lane_peak(input longint h0, input longint h1,
                                                     input longint h2, input longint h3);
    longint x, y, z, v, best;
    x = h2 - h0;
    y = 2 * h0 - 5 * h1 + 4 * h2 - h3;
    z = 3 * (h1 - h2) + h3 - h0;
    best = 128 * h1;
    if (best < 0) best = -best;
    for (longint k = 1; k < 4; k++) begin
      v = 128 * h1 + 16 * k * x + 4 * k * k * y + k * k * k * z;
      if (v < 0) v = -v;
      if (v > best) best = v;
    end
    if (best > longint'(PEAK_MAX)) best = longint'(PEAK_MAX);
    return best[PEAK_BITS-1:0];
  endfunction

  // shift a stereo word into the histories and work out its peaks
  task automatic predict_peaks(input stpe_in_t w, output stpe_out_t r);
    logic [PEAK_BITS-1:0] pl, pr;
    for (int i = 0; i < 3; i++) begin
      left_hist[i]  = left_hist[i+1];
      right_hist[i] = right_hist[i+1];
    end
    left_hist[3]  = w.left_sample;
    right_hist[3] = w.right_sample;
    pl = lane_peak(left_hist[0], left_hist[1], left_hist[2], left_hist[3]);
    pr = lane_peak(right_hist[0], right_hist[1], right_hist[2], right_hist[3]);
    r.item_peak_x128 = (pl > pr) ? pl : pr;
    if (r.item_peak_x128 > peak_hold_m) peak_hold_m = r.item_peak_x128;
    r.running_peak_x128 = peak_hold_m;
  endtask

  // mix of full-range noise, full scale, small values and scaled-down noise
  function automatic smp_t draw_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return smp_t'($urandom);
      4, 5:       return $urandom_range(1) ? FS_POS : FS_NEG;
      6:          return smp_t'(int'($urandom_range(511)) - 256);
      default:    return smp_t'($urandom) >>> $urandom_range(22);
    endcase
  endfunction

  // offer one word, wait for it to be taken, then queue its expected peaks
  task automatic send_word(input stpe_in_t w, input logic fixed, input stpe_out_t typed);
    stpe_out_t r;
    while (!calm && $urandom_range(99) < 12) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word  <= w;
    do @(posedge clk); while (sample_stall);
    predict_peaks(w, r);
    peak_due = {peak_due, (fixed ? typed : r)};
    words_sent++;
  endtask

  // stimulus
  initial begin
    stpe_in_t w;
    smp_t     prev_l, prev_r;
    for (int i = 0; i < 4; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    peak_hold_m = '0;
    prev_l = '0;
    prev_r = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++)
      send_word(dir_table[i].word, dir_table[i].fixed, dir_table[i].want);

    // random part: mostly fresh samples, some sign flips of the last one
    // to provoke overshoot, some identical channels
    for (int i = 0; i < N_RANDOM; i++) begin
      w.left_sample  = draw_sample();
      w.right_sample = draw_sample();
      case ($urandom_range(7))
        0: w.left_sample  = -prev_l;
        1: w.right_sample = -prev_r;
        2: w.right_sample = w.left_sample;
        default: ;
      endcase
      prev_l = w.left_sample;
      prev_r = w.right_sample;
      send_word(w, 1'b0, '0);
    end
    sample_valid <= 1'b0;

    // drain and let the pipeline settle
    while (peak_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // result check and random output stall
  always @(posedge clk) begin
    if (!rst && peak_valid && !peak_stall) begin
      if (peak_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected peak word: item %0d running %0d",
                   peak_word.item_peak_x128, peak_word.running_peak_x128);
      end else begin
        peak_want = peak_due.pop_front();
        if (peak_word.item_peak_x128 !== peak_want.item_peak_x128 ||
            peak_word.running_peak_x128 !== peak_want.running_peak_x128) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("peak mismatch: item exp %0d got %0d, running exp %0d got %0d",
                     peak_want.item_peak_x128, peak_word.item_peak_x128,
                     peak_want.running_peak_x128, peak_word.running_peak_x128);
        end
      end
    end
    peak_stall <= !calm && ($urandom_range(99) < 12);
  end

  // hang guard
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
design/stpe_pkg.sv
design/stpe_lane.sv
design/stpe_merge.sv
design/stereo_true_peak_estimator.sv
bench/stereo_true_peak_estimator_tb.sv
